// ===== design/scsp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo command stream parser package
// Shared constants, types and helper functions for the parser front end,
// the command queue and the command back end.
// ----------------------------------------------------------------------------
package scsp_pkg;

   // Default sizes handed to the top level
   localparam int DEF_MAX_TARGETS = 24;
   localparam int DEF_ARG_DEPTH   = 50;
   localparam int Q_DEPTH         = 4;

   // Framing bytes
   localparam logic [7:0] BYTE_ADDRESSED = 8'hAA;
   localparam logic [7:0] BYTE_MINI_SSC  = 8'hFF;
   localparam logic [7:0] DEV_ANY        = 8'hFF;
   localparam logic [7:0] DEV_RESET      = 8'd12;
   localparam logic [7:0] CRC_POLY       = 8'h91;
   localparam logic [7:0] CMD_HIGH_BIT   = 8'h80;

   // Command bytes
   localparam logic [7:0] CMD_SET_TARGET    = 8'h84;
   localparam logic [7:0] CMD_SET_SPEED     = 8'h87;
   localparam logic [7:0] CMD_SET_ACCEL     = 8'h89;
   localparam logic [7:0] CMD_SET_PWM       = 8'h8A;
   localparam logic [7:0] CMD_MULTI_TARGET  = 8'h9F;
   localparam logic [7:0] CMD_GET_POSITION  = 8'h90;
   localparam logic [7:0] CMD_GET_MOVING    = 8'h93;
   localparam logic [7:0] CMD_GET_ERRORS    = 8'hA1;
   localparam logic [7:0] CMD_GO_HOME       = 8'hA2;
   localparam logic [7:0] CMD_STOP_SCRIPT   = 8'hA4;
   localparam logic [7:0] CMD_RESTART       = 8'hA7;
   localparam logic [7:0] CMD_RESTART_PARAM = 8'hA8;
   localparam logic [7:0] CMD_GET_STATUS    = 8'hAE;

   // Configuration register indexes
   localparam logic [7:0] CSR_DEVICE_NUMBER = 8'd0;
   localparam logic [7:0] CSR_CRC_ENABLED   = 8'd1;

   typedef enum logic [3:0] {
      KIND_TARGET        = 4'd0,
      KIND_SPEED         = 4'd1,
      KIND_ACCEL         = 4'd2,
      KIND_PWM           = 4'd3,
      KIND_GET_POSITION  = 4'd4,
      KIND_GET_MOVING    = 4'd5,
      KIND_GET_ERRORS    = 4'd6,
      KIND_GO_HOME       = 4'd7,
      KIND_STOP_SCRIPT   = 4'd8,
      KIND_RESTART       = 4'd9,
      KIND_RESTART_PARAM = 4'd10,
      KIND_GET_STATUS    = 4'd11,
      KIND_MINI_SSC      = 4'd12
   } cmd_kind_type;

   typedef enum logic [2:0] {
      PS_IDLE,
      PS_DEV,
      PS_CMD,
      PS_ARGS,
      PS_CRC
   } parse_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FETCH,
      BK_LOAD
   } back_state_type;

   typedef struct packed {
      logic         known;
      cmd_kind_type kind;
      logic [2:0]   nargs;
   } cmd_info_type;

   // One decoded command waiting for the back end
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   channel;   // first channel for multi-target
      logic [13:0]  value;
      logic [15:0]  good;
      logic [15:0]  bad;
      logic         multi;
      logic [7:0]   count;     // number of targets for multi-target
   } cmd_desc_type;

   // Argument byte write from the front end
   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } arg_wr_type;

   // Back end status seen by the front end
   typedef struct packed {
      logic multi_done;
   } back_status_type;

   // Look up a command byte: argument count and result kind
   function automatic cmd_info_type cmd_lookup(input logic [7:0] c);
      cmd_info_type r;
      r.known = 1'b1;
      r.kind  = KIND_TARGET;
      r.nargs = 3'd0;
      case (c)
         CMD_SET_TARGET:    begin r.kind = KIND_TARGET;        r.nargs = 3'd3; end
         CMD_SET_SPEED:     begin r.kind = KIND_SPEED;         r.nargs = 3'd3; end
         CMD_SET_ACCEL:     begin r.kind = KIND_ACCEL;         r.nargs = 3'd3; end
         CMD_SET_PWM:       begin r.kind = KIND_PWM;           r.nargs = 3'd4; end
         CMD_MULTI_TARGET:  begin r.kind = KIND_TARGET;        r.nargs = 3'd1; end
         CMD_GET_POSITION:  begin r.kind = KIND_GET_POSITION;  r.nargs = 3'd1; end
         CMD_GET_MOVING:    begin r.kind = KIND_GET_MOVING;    r.nargs = 3'd0; end
         CMD_GET_ERRORS:    begin r.kind = KIND_GET_ERRORS;    r.nargs = 3'd0; end
         CMD_GO_HOME:       begin r.kind = KIND_GO_HOME;       r.nargs = 3'd0; end
         CMD_STOP_SCRIPT:   begin r.kind = KIND_STOP_SCRIPT;   r.nargs = 3'd0; end
         CMD_RESTART:       begin r.kind = KIND_RESTART;       r.nargs = 3'd1; end
         CMD_RESTART_PARAM: begin r.kind = KIND_RESTART_PARAM; r.nargs = 3'd3; end
         CMD_GET_STATUS:    begin r.kind = KIND_GET_STATUS;    r.nargs = 3'd0; end
         default:           begin r.known = 1'b0; end
      endcase
      return r;
   endfunction

   // CRC-7 over one byte, LSB first
   function automatic logic [7:0] crc7_step(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] c;
      c = acc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = c ^ CRC_POLY;
         end
         c = c >> 1;
      end
      return c;
   endfunction

endpackage

// ===== design/scsp_front.sv =====
// ----------------------------------------------------------------------------
// Servo command stream parser front end
// Framing state machine: takes serial bytes, checks CRC-7, counts good and
// bad commands, stores argument bytes and queues a descriptor for each good command that has a result.
// ----------------------------------------------------------------------------
module scsp_front import scsp_pkg::*; #(
   parameter int MAX_TARGETS = DEF_MAX_TARGETS,
   parameter int ARG_DEPTH   = DEF_ARG_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   input  logic [7:0]      req_rx_byte,
   output logic            req_full,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_index,
   input  logic [7:0]      csr_data,
   input  logic            q_full,
   output logic            push_en,
   output cmd_desc_type    push_desc,
   output arg_wr_type      arg_wr,
   input  back_status_type back_status
);

   localparam int NW      = $clog2(ARG_DEPTH + 1);
   localparam int FIT_LIM = (ARG_DEPTH - 2) / 2;
   localparam int CNT_LIM = (MAX_TARGETS < FIT_LIM) ? MAX_TARGETS : FIT_LIM;

   parse_state_type state_ff, state_in;
   logic [7:0]      dev_ff;
   logic            crc_en_ff;
   logic [7:0]      cmd_ff, cmd_in;
   logic [NW-1:0]   needed_ff, needed_in;
   logic [NW-1:0]   got_ff, got_in;
   logic [7:0]      crc_ff, crc_in;
   logic [15:0]     good_ff, good_in;
   logic [15:0]     bad_ff, bad_in;
   logic [7:0]      arg_ff [3];
   logic [7:0]      arg_in [3];
   logic            multi_busy_ff, multi_busy_in;

   logic            accept;
   logic            do_start;
   logic            do_begin;
   logic            check_done;
   logic            emit;
   logic [7:0]      begin_byte;
   logic [7:0]      b;
   logic [8:0]      multi_bytes;
   cmd_info_type    info;
   cmd_info_type    cur_info;
   cmd_desc_type    desc;
   logic [13:0]     val14;

   assign b         = req_rx_byte;
   assign req_full  = q_full || multi_busy_ff;
   assign accept    = req_push && !req_full;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff    <= DEV_RESET;
         crc_en_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DEVICE_NUMBER: dev_ff    <= csr_data;
            CSR_CRC_ENABLED:   crc_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Parse one byte
   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      needed_in   = needed_ff;
      got_in      = got_ff;
      crc_in      = crc_ff;
      good_in     = good_ff;
      bad_in      = bad_ff;
      arg_in      = arg_ff;
      do_start    = 1'b0;
      do_begin    = 1'b0;
      check_done  = 1'b0;
      emit        = 1'b0;
      begin_byte  = b;
      arg_wr.en   = 1'b0;
      arg_wr.addr = 8'(got_ff);
      arg_wr.data = b;
      multi_bytes = 9'd2 + {b, 1'b0};
      info        = cmd_lookup(b);

      if (accept) begin
         case (state_ff)
            PS_IDLE: begin
               do_start = b[7];
            end
            PS_DEV: begin
               if (crc_en_ff) crc_in = crc7_step(crc_ff, b);
               if (dev_ff != DEV_ANY && b != dev_ff) state_in = PS_IDLE;
               else state_in = PS_CMD;
            end
            PS_CMD: begin
               if (crc_en_ff) crc_in = crc7_step(crc_ff, b);
               do_begin   = 1'b1;
               begin_byte = b | CMD_HIGH_BIT;
            end
            PS_ARGS: begin
               if (cmd_ff != BYTE_MINI_SSC && b[7]) begin
                  // resync on a command byte mid-command
                  bad_in   = bad_in + 16'd1;
                  do_start = 1'b1;
               end else begin
                  if (cmd_ff != BYTE_MINI_SSC && crc_en_ff) crc_in = crc7_step(crc_ff, b);
                  if (got_ff < NW'(ARG_DEPTH)) begin
                     arg_wr.en = 1'b1;
                     got_in    = got_ff + NW'(1);
                  end
                  for (int k = 0; k < 3; k++) begin
                     if (got_ff == NW'(k)) arg_in[k] = b;
                  end
                  if (cmd_ff == CMD_MULTI_TARGET && got_in == NW'(1)) begin
                     if (b > 8'(CNT_LIM)) begin
                        bad_in   = bad_in + 16'd1;
                        state_in = PS_IDLE;
                     end else begin
                        needed_in = NW'(multi_bytes);
                     end
                  end
                  check_done = 1'b1;
               end
            end
            PS_CRC: begin
               state_in = PS_IDLE;
               if (b != crc_ff) begin
                  bad_in = bad_in + 16'd1;
               end else begin
                  good_in = good_in + 16'd1;
                  emit    = 1'b1;
               end
            end
            default: begin
               state_in = PS_IDLE;
            end
         endcase

         // Start of a fresh command
         if (do_start) begin
            if (b == BYTE_ADDRESSED) begin
               crc_in   = crc_en_ff ? crc7_step(8'd0, b) : 8'd0;
               state_in = PS_DEV;
            end else if (b == BYTE_MINI_SSC) begin
               cmd_in    = BYTE_MINI_SSC;
               got_in    = '0;
               needed_in = NW'(2);
               state_in  = PS_ARGS;
               check_done = 1'b1;
            end else begin
               crc_in     = crc_en_ff ? crc7_step(8'd0, b) : 8'd0;
               do_begin   = 1'b1;
               begin_byte = b;
            end
         end

         // Decode the command byte
         if (do_begin) begin
            info   = cmd_lookup(begin_byte);
            cmd_in = begin_byte;
            got_in = '0;
            if (!info.known) begin
               bad_in    = bad_in + 16'd1;
               needed_in = '0;
               state_in  = PS_IDLE;
            end else begin
               needed_in  = NW'(info.nargs);
               state_in   = PS_ARGS;
               check_done = 1'b1;
            end
         end

         // Complete the command once all argument bytes are in
         if (check_done && state_in == PS_ARGS && got_in >= needed_in) begin
            if (crc_en_ff && cmd_in != BYTE_MINI_SSC) begin
               state_in = PS_CRC;
            end else begin
               state_in = PS_IDLE;
               good_in  = good_in + 16'd1;
               emit     = 1'b1;
            end
         end
      end
   end

   // Build the descriptor
   assign val14    = {arg_in[2][6:0], arg_in[1][6:0]};
   assign cur_info = cmd_lookup(cmd_in);

   always_comb begin
      desc         = '0;
      desc.good    = good_in;
      desc.bad     = bad_in;
      desc.channel = arg_in[0];
      if (cmd_in == BYTE_MINI_SSC) begin
         desc.kind  = KIND_MINI_SSC;
         desc.value = {6'd0, arg_in[1]};
      end else if (cmd_in == CMD_MULTI_TARGET) begin
         desc.kind    = KIND_TARGET;
         desc.multi   = 1'b1;
         desc.count   = arg_in[0];
         desc.channel = arg_in[1];
      end else begin
         desc.kind = cur_info.kind;
         case (desc.kind) inside
            KIND_TARGET, KIND_SPEED, KIND_PWM, KIND_RESTART_PARAM: desc.value = val14;
            KIND_ACCEL:                      desc.value = {6'd0, val14[7:0]};
            KIND_GET_POSITION, KIND_RESTART: desc.value = '0;
            default:                         desc.channel = '0;
         endcase
      end
   end

   assign push_en   = emit && !(desc.multi && desc.count == 8'd0);
   assign push_desc = desc;

   // Hold input while a multi-target command reads its arguments
   always_comb begin
      multi_busy_in = multi_busy_ff;
      if (back_status.multi_done) multi_busy_in = 1'b0;
      if (push_en && desc.multi) multi_busy_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= PS_IDLE;
         cmd_ff        <= '0;
         needed_ff     <= '0;
         got_ff        <= '0;
         crc_ff        <= '0;
         good_ff       <= '0;
         bad_ff        <= '0;
         multi_busy_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmd_ff        <= cmd_in;
         needed_ff     <= needed_in;
         got_ff        <= got_in;
         crc_ff        <= crc_in;
         good_ff       <= good_in;
         bad_ff        <= bad_in;
         multi_busy_ff <= multi_busy_in;
      end
   end

   // First argument bytes, kept for single-result commands
   always_ff @(posedge clock) begin
      arg_ff <= arg_in;
   end

endmodule

// ===== design/scsp_queue.sv =====
// ----------------------------------------------------------------------------
// Servo command stream parser command queue
// Short first-in first-out store of command descriptors between the front
// end and the back end.
// ----------------------------------------------------------------------------
module scsp_queue import scsp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_en,
   input  cmd_desc_type push_desc,
   output logic         q_full,
   output logic         q_empty,
   input  logic         pop_en,
   output cmd_desc_type head_desc
);

   localparam int PW = $clog2(Q_DEPTH);
   localparam int CW = $clog2(Q_DEPTH + 1);

   cmd_desc_type  entry_ff [Q_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign q_full    = (count_ff == CW'(Q_DEPTH));
   assign q_empty   = (count_ff == '0);
   assign do_push   = push_en && !q_full;
   assign do_pop    = pop_en && !q_empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + PW'(1);
      if (do_pop)  rd_ptr_in = rd_ptr_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (!do_push && do_pop) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store descriptors
   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

// ===== design/scsp_back.sv =====
// ----------------------------------------------------------------------------
// Servo command stream parser back end
// Carries out queued commands: single results go straight to the output
// register; multi-target commands read target pairs from the argument
// memory and emit one set-target result per target.
// ----------------------------------------------------------------------------
module scsp_back import scsp_pkg::*; #(
   parameter int MAX_TARGETS = DEF_MAX_TARGETS,
   parameter int ARG_DEPTH   = DEF_ARG_DEPTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  cmd_desc_type    head_desc,
   output logic            pop_en,
   input  arg_wr_type      arg_wr,
   output back_status_type back_status,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output logic [3:0]      rsp_cmd_kind,
   output logic [7:0]      rsp_channel,
   output logic [13:0]     rsp_value,
   output logic [15:0]     rsp_good_count,
   output logic [15:0]     rsp_bad_count,
   output logic            rsp_last
);

   localparam int BANK_DEPTH = (ARG_DEPTH + 1) / 2;
   localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int TW         = $clog2(MAX_TARGETS + 1);

   back_state_type state_ff, state_in;
   cmd_desc_type   desc_ff, desc_in;
   logic [TW-1:0]  idx_ff, idx_in;
   logic           out_valid_ff, out_valid_in;
   logic [3:0]     out_kind_ff, out_kind_in;
   logic [7:0]     out_channel_ff, out_channel_in;
   logic [13:0]    out_value_ff, out_value_in;
   logic [15:0]    out_good_ff, out_good_in;
   logic [15:0]    out_bad_ff, out_bad_in;
   logic           out_last_ff, out_last_in;

   logic [7:0]     arg_even_mem [BANK_DEPTH];
   logic [7:0]     arg_odd_mem  [BANK_DEPTH];
   logic [7:0]     rd_even_ff;
   logic [7:0]     rd_odd_ff;
   logic [AW-1:0]  rd_addr;
   logic           rd_en;
   logic           load;
   logic           slot_free;
   logic           tgt_last;

   assign slot_free = !out_valid_ff || rsp_pop;
   assign rd_addr   = AW'(idx_ff) + AW'(1);
   assign tgt_last  = ((8'(idx_ff) + 8'd1) == desc_ff.count);

   // Argument memory, split into even and odd byte banks
   always_ff @(posedge clock) begin
      if (arg_wr.en && !arg_wr.addr[0]) arg_even_mem[arg_wr.addr[AW:1]] <= arg_wr.data;
      if (arg_wr.en && arg_wr.addr[0])  arg_odd_mem[arg_wr.addr[AW:1]]  <= arg_wr.data;
      if (rd_en) begin
         rd_even_ff <= arg_even_mem[rd_addr];
         rd_odd_ff  <= arg_odd_mem[rd_addr];
      end
   end

   // Sequence commands into results
   always_comb begin
      state_in       = state_ff;
      desc_in        = desc_ff;
      idx_in         = idx_ff;
      pop_en         = 1'b0;
      rd_en          = 1'b0;
      load           = 1'b0;
      back_status    = '0;
      out_kind_in    = out_kind_ff;
      out_channel_in = out_channel_ff;
      out_value_in   = out_value_ff;
      out_good_in    = out_good_ff;
      out_bad_in     = out_bad_ff;
      out_last_in    = out_last_ff;

      case (state_ff)
         BK_IDLE: begin
            if (!q_empty && slot_free) begin
               pop_en = 1'b1;
               if (head_desc.multi) begin
                  desc_in  = head_desc;
                  idx_in   = '0;
                  state_in = BK_FETCH;
               end else begin
                  load           = 1'b1;
                  out_kind_in    = head_desc.kind;
                  out_channel_in = head_desc.channel;
                  out_value_in   = head_desc.value;
                  out_good_in    = head_desc.good;
                  out_bad_in     = head_desc.bad;
                  out_last_in    = 1'b1;
               end
            end
         end
         BK_FETCH: begin
            rd_en    = 1'b1;
            state_in = BK_LOAD;
         end
         BK_LOAD: begin
            if (slot_free) begin
               load           = 1'b1;
               out_kind_in    = KIND_TARGET;
               out_channel_in = desc_ff.channel + 8'(idx_ff);
               out_value_in   = {rd_odd_ff[6:0], rd_even_ff[6:0]};
               out_good_in    = desc_ff.good;
               out_bad_in     = desc_ff.bad;
               out_last_in    = tgt_last;
               if (tgt_last) begin
                  back_status.multi_done = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_ff + TW'(1);
                  state_in = BK_FETCH;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_pop) out_valid_in = 1'b0;
      if (load)    out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff        <= desc_in;
      idx_ff         <= idx_in;
      out_kind_ff    <= out_kind_in;
      out_channel_ff <= out_channel_in;
      out_value_ff   <= out_value_in;
      out_good_ff    <= out_good_in;
      out_bad_ff     <= out_bad_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_cmd_kind   = out_kind_ff;
   assign rsp_channel    = out_channel_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_good_count = out_good_ff;
   assign rsp_bad_count  = out_bad_ff;
   assign rsp_last       = out_last_ff;

endmodule

// ===== design/servo_command_stream_parser_unit.sv =====
// ----------------------------------------------------------------------------
// Servo command stream parser unit
// Top level: parser front end, command queue and command back end.
// ----------------------------------------------------------------------------
// Takes one serial byte per clock on the req_ channel while req_full is low
// and returns decoded servo commands on the rsp_ channel, oldest first.
// Compact, addressed (0xAA) and Mini SSC (0xFF) framings are decoded, with
// an optional trailing CRC-7 byte. Every byte is parsed in the cycle it is
// accepted; a finished command enters a four-entry descriptor queue and
// passes from there to the result register, so single-result commands run
// at one byte per clock until the queue fills. A multi-target command
// produces one result per target, each by an argument memory read, then a
// result load; req_full rises in the cycle after the command's last byte
// and falls in the cycle after its final target is loaded. Configuration
// writes are always taken (csr_ready is tied high) and should only be made
// while the block is idle. No clearing pass follows reset.
module servo_command_stream_parser_unit import scsp_pkg::*; #(
   parameter int MAX_TARGETS = DEF_MAX_TARGETS,
   parameter int ARG_DEPTH   = DEF_ARG_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [7:0]  req_rx_byte,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [3:0]  rsp_cmd_kind,
   output logic [7:0]  rsp_channel,
   output logic [13:0] rsp_value,
   output logic [15:0] rsp_good_count,
   output logic [15:0] rsp_bad_count,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);

   logic            q_full;
   logic            q_empty;
   logic            push_en;
   logic            pop_en;
   cmd_desc_type    push_desc;
   cmd_desc_type    head_desc;
   arg_wr_type      arg_wr;
   back_status_type back_status;

   // Parse and classify bytes
   scsp_front #(
      .MAX_TARGETS(MAX_TARGETS),
      .ARG_DEPTH  (ARG_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_rx_byte(req_rx_byte),
      .req_full   (req_full),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_full     (q_full),
      .push_en    (push_en),
      .push_desc  (push_desc),
      .arg_wr     (arg_wr),
      .back_status(back_status)
   );

   // Buffer decoded commands
   scsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_en  (push_en),
      .push_desc(push_desc),
      .q_full   (q_full),
      .q_empty  (q_empty),
      .pop_en   (pop_en),
      .head_desc(head_desc)
   );

   // Emit results
   scsp_back #(
      .MAX_TARGETS(MAX_TARGETS),
      .ARG_DEPTH  (ARG_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .head_desc     (head_desc),
      .pop_en        (pop_en),
      .arg_wr        (arg_wr),
      .back_status   (back_status),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cmd_kind  (rsp_cmd_kind),
      .rsp_channel   (rsp_channel),
      .rsp_value     (rsp_value),
      .rsp_good_count(rsp_good_count),
      .rsp_bad_count (rsp_bad_count),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== design/scsp_checker.sv =====
// ----------------------------------------------------------------------------
// Servo command stream parser checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module scsp_checker import scsp_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [3:0]  rsp_cmd_kind,
   input logic [13:0] rsp_value,
   input logic [15:0] rsp_good_count,
   input logic        rsp_last
);

   // Result kind stays within the defined codes
   kind_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_cmd_kind <= KIND_MINI_SSC)
      else $error("result kind out of range");

   // Only multi-target bursts carry results that are not last
   burst_kind: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_last) |-> rsp_cmd_kind == KIND_TARGET)
      else $error("non-final result is not a set-target");

   // Mini SSC and accel values fit in eight bits
   byte_value: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_cmd_kind == KIND_MINI_SSC || rsp_cmd_kind == KIND_ACCEL))
         |-> rsp_value[13:8] == 6'd0)
      else $error("eight-bit value has high bits set");

   // A waiting result holds until transfer
   hold_result: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_value)
         && $stable(rsp_good_count)))
      else $error("waiting result changed before transfer");

endmodule

bind servo_command_stream_parser_unit scsp_checker u_scsp_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Servo command stream parser testbench
// Feeds serial command bytes into the parser and checks every decoded command
// against a cycle-free predictor kept in step with each accepted byte. Covers
// compact, addressed and Mini SSC framings, CRC-7 on and off, resync, stray
// and unknown bytes, multi-target bursts, random traffic under idling and
// stalls, and a long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb;
   import scsp_pkg::*;

   localparam int MAX_TARGETS   = DEF_MAX_TARGETS;
   localparam int ARG_DEPTH     = DEF_ARG_DEPTH;
   localparam int PHASE_BYTES   = 12;
   localparam int SETTLE_CYCLES = 64;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   channel;
      logic [13:0]  value;
      logic [15:0]  good;
      logic [15:0]  bad;
      logic         last;
   } servo_cmd_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_push    = 1'b0;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop     = 1'b0;
   logic [3:0]  rsp_cmd_kind;
   logic [7:0]  rsp_channel;
   logic [13:0] rsp_value;
   logic [15:0] rsp_good_count;
   logic [15:0] rsp_bad_count;
   logic        rsp_last;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index   = 8'd0;
   logic [7:0]  csr_data    = 8'd0;

   // Predicted parser state and configuration
   parse_state_type ps       = PS_IDLE;
   logic [7:0]      cur_cmd  = 8'd0;
   logic [8:0]      need     = 9'd0;
   logic [8:0]      got      = 9'd0;
   logic [7:0]      crc_acc  = 8'd0;
   logic [7:0]      args [ARG_DEPTH];
   logic [15:0]     good_cnt = 16'd0;
   logic [15:0]     bad_cnt  = 16'd0;
   logic [7:0]      cfg_dev  = DEV_RESET;
   logic            cfg_crc  = 1'b0;

   servo_cmd_type pending_cmds[$];
   logic [7:0] frame_bytes[$];

   int error_count  = 0;
   int byte_count   = 0;
   int result_count = 0;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int rx_hold      = 0;

   servo_command_stream_parser_unit #(
      .MAX_TARGETS(MAX_TARGETS),
      .ARG_DEPTH  (ARG_DEPTH)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_rx_byte   (req_rx_byte),
      .req_full      (req_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_cmd_kind  (rsp_cmd_kind),
      .rsp_channel   (rsp_channel),
      .rsp_value     (rsp_value),
      .rsp_good_count(rsp_good_count),
      .rsp_bad_count (rsp_bad_count),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      foreach (args[i]) args[i] = 8'd0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // CRC-7 fold of one byte, LSB first
   function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
      logic [7:0] r;
      r = acc ^ b;
      repeat (8) begin
         r = r[0] ? ((r >> 1) ^ (CRC_POLY >> 1)) : (r >> 1);
      end
      return r;
   endfunction

   // Data bytes a command takes, -1 when the byte is no known command
   function automatic int cmd_arg_count(input logic [7:0] c, output cmd_kind_type k);
      int n;
      k = KIND_TARGET;
      n = -1;
      case (c)
         CMD_SET_TARGET:    begin k = KIND_TARGET;        n = 3; end
         CMD_SET_SPEED:     begin k = KIND_SPEED;         n = 3; end
         CMD_SET_ACCEL:     begin k = KIND_ACCEL;         n = 3; end
         CMD_SET_PWM:       begin k = KIND_PWM;           n = 4; end
         CMD_MULTI_TARGET:  begin k = KIND_TARGET;        n = 1; end
         CMD_GET_POSITION:  begin k = KIND_GET_POSITION;  n = 1; end
         CMD_GET_MOVING:    begin k = KIND_GET_MOVING;    n = 0; end
         CMD_GET_ERRORS:    begin k = KIND_GET_ERRORS;    n = 0; end
         CMD_GO_HOME:       begin k = KIND_GO_HOME;       n = 0; end
         CMD_STOP_SCRIPT:   begin k = KIND_STOP_SCRIPT;   n = 0; end
         CMD_RESTART:       begin k = KIND_RESTART;       n = 1; end
         CMD_RESTART_PARAM: begin k = KIND_RESTART_PARAM; n = 3; end
         CMD_GET_STATUS:    begin k = KIND_GET_STATUS;    n = 0; end
         default:           begin n = -1; end
      endcase
      return n;
   endfunction

   function automatic logic [7:0] arg_byte(input int i);
      return (i < ARG_DEPTH) ? args[i] : 8'd0;
   endfunction

   // 14-bit value from a low then a high seven-bit byte
   function automatic logic [13:0] arg_value(input int i);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = arg_byte(i);
      hi = arg_byte(i + 1);
      return {hi[6:0], lo[6:0]};
   endfunction

   task automatic crc_absorb(input logic [7:0] b);
      if (cfg_crc) crc_acc = crc_fold(crc_acc, b);
   endtask

   task automatic push_expect(input cmd_kind_type k, input logic [7:0] ch,
                              input logic [13:0] v, input logic lst);
      servo_cmd_type e;
      e.kind    = k;
      e.channel = ch;
      e.value   = v;
      e.good    = good_cnt;
      e.bad     = bad_cnt;
      e.last    = lst;
      pending_cmds.push_back(e);
   endtask

   task automatic open_command(input logic [7:0] c);
      cmd_kind_type k;
      int n;
      n = cmd_arg_count(c, k);
      cur_cmd = c;
      got = 9'd0;
      if (n < 0) begin
         bad_cnt++;
         need = 9'd0;
         ps = PS_IDLE;
      end else begin
         need = 9'(n);
         ps = PS_ARGS;
      end
   endtask

   task automatic frame_start(input logic [7:0] b);
      if (b == BYTE_ADDRESSED) begin
         crc_acc = 8'd0;
         crc_absorb(b);
         ps = PS_DEV;
      end else if (b == BYTE_MINI_SSC) begin
         cur_cmd = BYTE_MINI_SSC;
         got = 9'd0;
         need = 9'd2;
         ps = PS_ARGS;
      end else begin
         crc_acc = 8'd0;
         crc_absorb(b);
         open_command(b);
      end
   endtask

   // Expected results of the command just completed
   task automatic queue_results();
      cmd_kind_type k;
      logic [7:0] ch;
      logic [13:0] v;
      int n;
      if (cur_cmd == BYTE_MINI_SSC) begin
         push_expect(KIND_MINI_SSC, arg_byte(0), {6'd0, arg_byte(1)}, 1'b1);
      end else if (cur_cmd == CMD_MULTI_TARGET) begin
         n = int'(arg_byte(0));
         for (int i = 0; i < n && i < MAX_TARGETS; i++) begin
            push_expect(KIND_TARGET, 8'(arg_byte(1) + i), arg_value(2 + 2 * i), (i + 1 == n));
         end
      end else begin
         n = cmd_arg_count(cur_cmd, k);
         ch = arg_byte(0);
         v = 14'd0;
         case (k)
            KIND_TARGET, KIND_SPEED, KIND_PWM, KIND_RESTART_PARAM: v = arg_value(1);
            KIND_ACCEL: v = arg_value(1) & 14'h00FF;
            KIND_GET_POSITION, KIND_RESTART: v = 14'd0;
            default: ch = 8'd0;
         endcase
         push_expect(k, ch, v, 1'b1);
      end
   endtask

   // Advance the predicted parser by one accepted byte
   task automatic decode_byte(input logic [7:0] b);
      case (ps)
         PS_IDLE: begin
            if (b[7]) frame_start(b);
         end
         PS_DEV: begin
            crc_absorb(b);
            if (cfg_dev != DEV_ANY && b != cfg_dev) ps = PS_IDLE;
            else ps = PS_CMD;
         end
         PS_CMD: begin
            crc_absorb(b);
            open_command(b | CMD_HIGH_BIT);
         end
         PS_ARGS: begin
            if (cur_cmd != BYTE_MINI_SSC && b[7]) begin
               // resync: drop the unfinished command
               bad_cnt++;
               frame_start(b);
            end else begin
               if (cur_cmd != BYTE_MINI_SSC) crc_absorb(b);
               if (got < ARG_DEPTH) args[got] = b;
               if (got < 9'h1FF) got++;
               if (cur_cmd == CMD_MULTI_TARGET && got == 9'd1) begin
                  if (int'(b) > MAX_TARGETS || 2 + 2 * int'(b) > ARG_DEPTH) begin
                     bad_cnt++;
                     ps = PS_IDLE;
                  end else begin
                     need = 9'(2 + 2 * int'(b));
                  end
               end
            end
         end
         PS_CRC: begin
            ps = PS_IDLE;
            if (b != crc_acc) begin
               bad_cnt++;
            end else begin
               good_cnt++;
               queue_results();
            end
         end
         default: ps = PS_IDLE;
      endcase
      if (ps == PS_ARGS && got >= need) begin
         if (cfg_crc && cur_cmd != BYTE_MINI_SSC) begin
            ps = PS_CRC;
         end else begin
            ps = PS_IDLE;
            good_cnt++;
            queue_results();
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] seen,
                                  input logic [31:0] want);
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, seen, want);
      error_count++;
   endtask

   task automatic check_result();
      servo_cmd_type w;
      if (pending_cmds.size() == 0) begin
         report_mismatch("result with none pending, kind", 32'(rsp_cmd_kind), 32'd0);
         return;
      end
      w = pending_cmds.pop_front();
      result_count++;
      if (rsp_cmd_kind !== w.kind)
         report_mismatch("cmd_kind", 32'(rsp_cmd_kind), 32'(w.kind));
      if (rsp_channel !== w.channel)
         report_mismatch("channel", 32'(rsp_channel), 32'(w.channel));
      if (rsp_value !== w.value)
         report_mismatch("value", 32'(rsp_value), 32'(w.value));
      if (rsp_good_count !== w.good)
         report_mismatch("good_count", 32'(rsp_good_count), 32'(w.good));
      if (rsp_bad_count !== w.bad)
         report_mismatch("bad_count", 32'(rsp_bad_count), 32'(w.bad));
      if (rsp_last !== w.last)
         report_mismatch("last", 32'(rsp_last), 32'(w.last));
   endtask

   // Receiver: check each transfer, then decide the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_result();
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (rx_hold > 0) begin
         rx_hold--;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < tx_idle_pct);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_full);
      decode_byte(b);
      byte_count++;
   endtask

   task automatic send_frame();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // Hold the sender until every pending command has come out
   task automatic wait_drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_DEVICE_NUMBER) cfg_dev = data;
      else if (idx == CSR_CRC_ENABLED) cfg_crc = data[0];
      @(posedge clock);
   endtask

   task automatic append_crc(input logic corrupt);
      logic [7:0] acc;
      acc = 8'd0;
      foreach (frame_bytes[i]) acc = crc_fold(acc, frame_bytes[i]);
      if (corrupt) acc = acc ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(acc);
   endtask

   function automatic logic [7:0] data7();
      int r;
      r = $urandom_range(0, 19);
      if (r < 3) return 8'h00;
      if (r < 6) return 8'h7F;
      return 8'($urandom_range(0, 127));
   endfunction

   function automatic logic [7:0] single_cmd(input int i);
      case (i)
         0:  return CMD_SET_TARGET;
         1:  return CMD_SET_SPEED;
         2:  return CMD_SET_ACCEL;
         3:  return CMD_SET_PWM;
         4:  return CMD_GET_POSITION;
         5:  return CMD_GET_MOVING;
         6:  return CMD_GET_ERRORS;
         7:  return CMD_GO_HOME;
         8:  return CMD_STOP_SCRIPT;
         9:  return CMD_RESTART;
         10: return CMD_RESTART_PARAM;
         default: return CMD_GET_STATUS;
      endcase
   endfunction

   function automatic logic [7:0] unknown_cmd();
      logic [7:0] c;
      cmd_kind_type k;
      do begin
         c = 8'($urandom_range(128, 255));
      end while (cmd_arg_count(c, k) >= 0 || c == BYTE_ADDRESSED || c == BYTE_MINI_SSC);
      return c;
   endfunction

   // Mostly short target lists, a few long ones, some too long
   function automatic int target_count();
      int r;
      r = $urandom_range(0, 19);
      if (r < 14) return $urandom_range(0, 4);
      if (r < 18) return $urandom_range(5, MAX_TARGETS);
      return $urandom_range(MAX_TARGETS + 1, 127);
   endfunction

   // One random frame: mostly well formed, some noise and cut-off frames
   task automatic make_random_frame();
      int sel;
      int n;
      int cnt;
      logic [7:0] c;
      cmd_kind_type k;
      logic with_crc;
      frame_bytes.delete();
      with_crc = cfg_crc;
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
         cnt = $urandom_range(1, 3);
         repeat (cnt) frame_bytes.push_back(8'($urandom_range(0, 255)));
         with_crc = 1'b0;
      end else if (sel < 18) begin
         frame_bytes.push_back(BYTE_MINI_SSC);
         frame_bytes.push_back(8'($urandom_range(0, 255)));
         frame_bytes.push_back(8'($urandom_range(0, 255)));
         with_crc = 1'b0;
      end else if (sel < 32) begin
         cnt = target_count();
         frame_bytes.push_back(CMD_MULTI_TARGET);
         frame_bytes.push_back(8'(cnt));
         if (cnt > MAX_TARGETS) begin
            with_crc = 1'b0;
         end else begin
            frame_bytes.push_back(data7());
            repeat (cnt) begin
               frame_bytes.push_back(data7());
               frame_bytes.push_back(data7());
            end
         end
      end else begin
         if ($urandom_range(0, 19) == 0) c = unknown_cmd();
         else c = single_cmd($urandom_range(0, 11));
         n = cmd_arg_count(c, k);
         if ($urandom_range(0, 2) == 0) begin
            frame_bytes.push_back(BYTE_ADDRESSED);
            if ($urandom_range(0, 3) == 0) frame_bytes.push_back(8'($urandom_range(0, 255)));
            else frame_bytes.push_back(cfg_dev);
            if ($urandom_range(0, 1) == 0) frame_bytes.push_back(c & ~CMD_HIGH_BIT);
            else frame_bytes.push_back(c);
         end else begin
            frame_bytes.push_back(c);
         end
         if (n > 0) repeat (n) frame_bytes.push_back(data7());
      end
      if (with_crc) append_crc($urandom_range(0, 9) == 0);
      // cut the tail off now and then
      if (frame_bytes.size() > 1 && $urandom_range(0, 11) == 0) begin
         cnt = $urandom_range(1, frame_bytes.size() - 1);
         repeat (cnt) void'(frame_bytes.pop_back());
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Every command once, field extremes, both Mini SSC extremes
   task automatic test_compact_commands();
      frame_bytes = '{CMD_SET_TARGET, 8'h00, 8'h00, 8'h00,
                      CMD_SET_SPEED, 8'h7F, 8'h7F, 8'h7F,
                      CMD_SET_ACCEL, 8'h7F, 8'h7F, 8'h01,
                      CMD_SET_PWM, 8'h01, 8'h55, 8'h2A, 8'h00,
                      CMD_GET_POSITION, 8'h05,
                      CMD_GET_MOVING, CMD_GET_ERRORS, CMD_GO_HOME, CMD_STOP_SCRIPT,
                      CMD_RESTART, 8'h7F,
                      CMD_RESTART_PARAM, 8'h00, 8'h7F, 8'h7F,
                      CMD_GET_STATUS,
                      BYTE_MINI_SSC, 8'hFF, 8'hFF,
                      BYTE_MINI_SSC, 8'h00, 8'h00,
                      CMD_MULTI_TARGET, 8'h02, 8'h7E, 8'h7F, 8'h7F, 8'h00, 8'h00,
                      CMD_MULTI_TARGET, 8'h00, 8'h05};
      send_frame();
      wait_drain();
   endtask

   // Stray data, unknown and resynced commands, addressing, oversize lists
   task automatic test_stream_errors();
      frame_bytes = '{8'h00, 8'h7F,
                      8'h80,
                      CMD_SET_TARGET, 8'h01, CMD_SET_SPEED, 8'h02, 8'h03, 8'h04,
                      BYTE_ADDRESSED, DEV_RESET, 8'h04, 8'h03, 8'h10, 8'h20,
                      BYTE_ADDRESSED, 8'h05, 8'h04, 8'h01, 8'h02, 8'h03,
                      CMD_MULTI_TARGET, 8'(MAX_TARGETS + 1), 8'h01, 8'h02,
                      BYTE_MINI_SSC, CMD_SET_TARGET, BYTE_ADDRESSED,
                      BYTE_ADDRESSED, DEV_RESET, 8'h7F,
                      CMD_SET_TARGET, 8'h05, CMD_GET_ERRORS,
                      CMD_GET_STATUS};
      send_frame();
      wait_drain();
   endtask

   // Trailing CRC: good, bad, high-bit bad byte, addressing at both extremes
   task automatic test_crc_frames();
      csr_write(CSR_DEVICE_NUMBER, DEV_ANY);
      csr_write(CSR_CRC_ENABLED, 8'd1);
      frame_bytes = '{CMD_SET_TARGET, 8'h01, 8'h7F, 8'h7F};
      append_crc(1'b0);
      send_frame();
      frame_bytes = '{BYTE_ADDRESSED, 8'h33, 8'h04, 8'h02, 8'h10, 8'h20};
      append_crc(1'b0);
      send_frame();
      frame_bytes = '{CMD_GET_ERRORS};
      append_crc(1'b0);
      send_frame();
      frame_bytes = '{CMD_SET_SPEED, 8'h01, 8'h02, 8'h03};
      append_crc(1'b1);
      send_frame();
      frame_bytes = '{BYTE_MINI_SSC, 8'h10, 8'h80};
      send_frame();
      frame_bytes = '{CMD_MULTI_TARGET, 8'h01, 8'h05, 8'h40, 8'h3F};
      append_crc(1'b0);
      send_frame();
      // wrong check byte that looks like a command byte: must not start one
      frame_bytes = '{CMD_GO_HOME};
      append_crc(1'b0);
      if (frame_bytes[1] != CMD_SET_TARGET) frame_bytes[1] = CMD_SET_TARGET;
      else frame_bytes[1] = CMD_SET_SPEED;
      frame_bytes.push_back(8'h01);
      frame_bytes.push_back(8'h02);
      frame_bytes.push_back(8'h03);
      send_frame();
      frame_bytes = '{CMD_GET_STATUS};
      append_crc(1'b0);
      send_frame();
      wait_drain();
      csr_write(CSR_DEVICE_NUMBER, 8'd0);
      csr_write(CSR_CRC_ENABLED, 8'd0);
      frame_bytes = '{BYTE_ADDRESSED, 8'h00, 8'h04, 8'h05, 8'h06, 8'h07,
                      BYTE_ADDRESSED, DEV_ANY, 8'h04, 8'h05, 8'h06, 8'h07};
      send_frame();
      wait_drain();
   endtask

   // Stall the receiver long enough to fill the block and block the input
   task automatic test_back_pressure();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      rx_hold = 300;
      repeat (12) begin
         frame_bytes = '{CMD_GET_STATUS};
         send_frame();
      end
      frame_bytes = '{CMD_MULTI_TARGET, 8'(MAX_TARGETS), 8'h00};
      repeat (MAX_TARGETS) begin
         frame_bytes.push_back(data7());
         frame_bytes.push_back(data7());
      end
      frame_bytes.push_back(CMD_GET_MOVING);
      send_frame();
      wait_drain();
      rx_hold = 150;
      frame_bytes = '{CMD_MULTI_TARGET, 8'd4, 8'h40};
      repeat (4) begin
         frame_bytes.push_back(data7());
         frame_bytes.push_back(data7());
      end
      frame_bytes.push_back(CMD_SET_TARGET);
      frame_bytes.push_back(8'h7F);
      frame_bytes.push_back(8'h7F);
      frame_bytes.push_back(8'h7F);
      send_frame();
      wait_drain();
   endtask

   task automatic run_random_phase(input logic [7:0] dev, input logic crc_on,
                                   input int tx_pct, input int rx_pct);
      int start;
      wait_drain();
      csr_write(CSR_DEVICE_NUMBER, dev);
      csr_write(CSR_CRC_ENABLED, {7'd0, crc_on});
      tx_idle_pct = tx_pct;
      rx_stall_pct = rx_pct;
      start = byte_count;
      while (byte_count - start < PHASE_BYTES) begin
         make_random_frame();
         send_frame();
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(DEV_ANY, 1'b0, 0, 0);
      run_random_phase(8'd0, 1'b1, 86, 0);
      run_random_phase(8'($urandom_range(1, 254)), 1'b1, 0, 86);
      run_random_phase(8'd127, 1'b0, 31, 31);
      wait_drain();
      tx_idle_pct = 0;
      rx_stall_pct = 0;
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_compact_commands();
      test_stream_errors();
      test_crc_frames();
      test_back_pressure();
      test_random_traffic();
      wait_drain();
      $display("Run covered %0d bytes in and %0d commands out (%0d good, %0d bad counted)",
               byte_count, result_count, good_cnt, bad_cnt);
      $display("Framings compact, addressed and Mini SSC, CRC off and on, idle/stall/hold-off");
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Guard against a hung handshake
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
